### rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator package
// Shared codes and control types for the allocator and its slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} policy_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_REQ  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_LOADED  = 2'd0,
		ST_GRANTED = 2'd1,
		ST_NOFIT   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_FINISH = 2'd2
	} state_t;

	typedef struct packed {
		policy_t policy;
		logic    wr_en;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/fpfa_if.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpfa_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  slot_index;
	logic [15:0] amount;

	modport source (output valid, kind, slot_index, amount, input ready);
	modport sink (input valid, kind, slot_index, amount, output ready);
endinterface

interface fpfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  chosen_slot;
	logic [15:0] slot_remaining;

	modport source (output valid, status, chosen_slot, slot_remaining, input ready);
	modport sink (input valid, status, chosen_slot, slot_remaining, output ready);
endinterface

`default_nettype wire

### rtl/fpfa_cell.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator slot cell
// Holds one slot's free space and refines the passing search candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_cell import fpfa_pkg::*; #(
	parameter int IDX = 0,
	parameter int IW  = 3,
	parameter int SW  = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire logic [SW-1:0] need,
	input  wire logic [IW-1:0] start,
	input  wire logic [IW-1:0] wr_idx,
	input  wire logic [SW-1:0] wr_val,
	input  wire logic          tok_i,
	input  wire logic          a_hit_i,
	input  wire logic [IW-1:0] a_idx_i,
	input  wire logic [SW-1:0] a_val_i,
	input  wire logic          b_hit_i,
	input  wire logic [IW-1:0] b_idx_i,
	input  wire logic [SW-1:0] b_val_i,
	output logic               tok_o,
	output logic               a_hit_o,
	output logic [IW-1:0]      a_idx_o,
	output logic [SW-1:0]      a_val_o,
	output logic               b_hit_o,
	output logic [IW-1:0]      b_idx_o,
	output logic [SW-1:0]      b_val_o
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [SW-1:0] free_q;
	logic          fits;
	logic          take_a;
	logic          take_b;

	always_comb begin
		fits = (free_q >= need);
		unique case (ctl.policy)
			POL_BEST:  take_a = fits && (!a_hit_i || (free_q < a_val_i));
			POL_WORST: take_a = fits && (!a_hit_i || (free_q > a_val_i));
			default:   take_a = fits && !a_hit_i && (MY_IDX >= start);
		endcase
		take_b = fits && !b_hit_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
			tok_o  <= 1'b0;
		end else begin
			tok_o <= tok_i;
			if (ctl.wr_en && (wr_idx == MY_IDX)) begin
				free_q <= wr_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_hit_o <= a_hit_i || take_a;
		a_idx_o <= take_a ? MY_IDX : a_idx_i;
		a_val_o <= take_a ? free_q : a_val_i;
		b_hit_o <= b_hit_i || take_b;
		b_idx_o <= take_b ? MY_IDX : b_idx_i;
		b_val_o <= take_b ? free_q : b_val_i;
	end

endmodule

`default_nettype wire

### rtl/fixed_partition_fit_allocator_top.sv
// A load goes from its transfer to the finish step and from there to the output register; a
// request first passes the scan step. One item at a time: a request occupies the block while
// the search candidate walks the chain of SLOTS slot cells, one cell per cycle, and through
// its finish step; a load skips the scan. Results wait in an output register.
// Reset clears every slot to zero free space, the policy to first fit and the next-fit
// start slot to zero.
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// Tracks free space of fixed slots and grants requests by a configurable fit policy.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator_top import fpfa_pkg::*; #(
	parameter int SLOTS      = 8,
	parameter int SIZE_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic [1:0] cfg_wdata,
	fpfa_req_if.sink   req,
	fpfa_rsp_if.source rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW = SIZE_WIDTH;

	state_t        state_q;
	state_t        state_d;
	policy_t       policy_q;
	logic [IW-1:0] next_start_q;
	logic          launch_q;
	kind_t         kind_q;
	logic [2:0]    sidx_q;
	logic [SW-1:0] need_q;
	logic          res_hit_q;
	logic [IW-1:0] res_idx_q;
	logic [SW-1:0] res_val_q;
	logic          out_valid_q;
	status_t       out_status_q;
	logic [2:0]    out_slot_q;
	logic [15:0]   out_rem_q;

	logic          tok   [0:SLOTS];
	logic          a_hit [0:SLOTS];
	logic [IW-1:0] a_idx [0:SLOTS];
	logic [SW-1:0] a_val [0:SLOTS];
	logic          b_hit [0:SLOTS];
	logic [IW-1:0] b_idx [0:SLOTS];
	logic [SW-1:0] b_val [0:SLOTS];

	cell_ctl_t     ctl;
	logic [IW-1:0] start;
	logic [IW-1:0] wr_idx;
	logic [SW-1:0] wr_val;
	logic          accept;
	logic          out_free;
	logic          finish;
	logic          in_range;
	logic [SW+15:0] amt_ext;
	logic [IW+2:0] sidx_ext;
	logic [IW+2:0] pick_ext;
	logic [SW-1:0] new_val;
	logic [SW+15:0] need_ext;
	logic [SW+15:0] new_ext;
	logic          pick_hit;
	logic [IW-1:0] pick_idx;
	logic [SW-1:0] pick_val;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign finish   = (state_q == S_FINISH) && out_free;
	assign req.ready = (state_q == S_IDLE);

	assign amt_ext  = {{SW{1'b0}}, req.amount};
	assign sidx_ext = {{IW{1'b0}}, sidx_q};
	assign in_range = (32'(sidx_q) < 32'(SLOTS));
	assign new_val  = res_val_q - need_q;
	assign need_ext = {16'b0, need_q};
	assign new_ext  = {16'b0, new_val};
	assign pick_ext = {3'b000, res_idx_q};

	assign start = (policy_q == POL_NEXT) ? next_start_q : '0;

	always_comb begin
		ctl.policy = policy_q;
		ctl.wr_en  = 1'b0;
		wr_idx     = res_idx_q;
		wr_val     = new_val;
		if (finish) begin
			if (kind_q == KIND_LOAD) begin
				ctl.wr_en = in_range;
				wr_idx    = sidx_ext[IW-1:0];
				wr_val    = need_q;
			end else begin
				ctl.wr_en = res_hit_q;
			end
		end
	end

	always_comb begin
		if (a_hit[SLOTS]) begin
			pick_hit = 1'b1;
			pick_idx = a_idx[SLOTS];
			pick_val = a_val[SLOTS];
		end else if (b_hit[SLOTS] && (policy_q == POL_NEXT)) begin
			pick_hit = 1'b1;
			pick_idx = b_idx[SLOTS];
			pick_val = b_val[SLOTS];
		end else begin
			pick_hit = 1'b0;
			pick_idx = b_idx[SLOTS];
			pick_val = b_val[SLOTS];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (kind_t'(req.kind) == KIND_REQ) ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (tok[SLOTS]) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= POL_FIRST;
			next_start_q <= '0;
			launch_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept && (kind_t'(req.kind) == KIND_REQ);
			if (cfg_we) begin
				policy_q <= policy_t'(cfg_wdata);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				if ((kind_q == KIND_REQ) && res_hit_q && (policy_q == POL_NEXT)) begin
					next_start_q <= res_idx_q;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(req.kind);
			sidx_q <= req.slot_index;
			need_q <= amt_ext[SW-1:0];
		end
		if ((state_q == S_SCAN) && tok[SLOTS]) begin
			res_hit_q <= pick_hit;
			res_idx_q <= pick_idx;
			res_val_q <= pick_val;
		end
		if (finish) begin
			if (kind_q == KIND_LOAD) begin
				out_status_q <= ST_LOADED;
				out_slot_q   <= sidx_q;
				out_rem_q    <= in_range ? need_ext[15:0] : 16'd0;
			end else if (res_hit_q) begin
				out_status_q <= ST_GRANTED;
				out_slot_q   <= pick_ext[2:0];
				out_rem_q    <= new_ext[15:0];
			end else begin
				out_status_q <= ST_NOFIT;
				out_slot_q   <= 3'd0;
				out_rem_q    <= 16'd0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.chosen_slot    = out_slot_q;
	assign rsp.slot_remaining = out_rem_q;

	assign tok[0]   = launch_q;
	assign a_hit[0] = 1'b0;
	assign a_idx[0] = '0;
	assign a_val[0] = '0;
	assign b_hit[0] = 1'b0;
	assign b_idx[0] = '0;
	assign b_val[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		fpfa_cell #(
			.IDX (i),
			.IW  (IW),
			.SW  (SW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.need    (need_q),
			.start   (start),
			.wr_idx  (wr_idx),
			.wr_val  (wr_val),
			.tok_i   (tok[i]),
			.a_hit_i (a_hit[i]),
			.a_idx_i (a_idx[i]),
			.a_val_i (a_val[i]),
			.b_hit_i (b_hit[i]),
			.b_idx_i (b_idx[i]),
			.b_val_i (b_val[i]),
			.tok_o   (tok[i+1]),
			.a_hit_o (a_hit[i+1]),
			.a_idx_o (a_idx[i+1]),
			.a_val_o (a_val[i+1]),
			.b_hit_o (b_hit[i+1]),
			.b_idx_o (b_idx[i+1]),
			.b_val_o (b_val[i+1])
		);
	end

	// The search candidate only leaves the chain while a request is being scanned.
	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[SLOTS] |-> (state_q == S_SCAN))
		else $error("search candidate left the chain outside a scan");

	// A request transfer starts exactly one candidate down the chain.
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind) |=> (launch_q && (state_q == S_SCAN)))
		else $error("request transfer did not launch a scan");

	// A refused request reports slot zero with nothing remaining.
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_NOFIT)) |-> ((out_slot_q == 3'd0) && (out_rem_q == 16'd0)))
		else $error("refused request carries a slot or remaining space");

	// Slot storage is only written while a transfer is being finished.
	a_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> ((state_q == S_FINISH) && out_free))
		else $error("slot written outside the finish step");

endmodule

`default_nettype wire

### tb/fpfa_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocator result checker
// Keeps its own copy of the slot free space, the next-fit start slot and the
// policy. Each accepted item is turned into the expected result. Each result
// transfer is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------

module fpfa_alloc_checker import fpfa_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	fpfa_req_if        req,
	fpfa_rsp_if        rsp,
	output int         fails,
	output int         pending
);

	typedef struct packed {
		status_t     status;
		logic [2:0]  slot;
		logic [15:0] remaining;
	} alloc_result_t;

	logic [15:0]   slot_free [SLOTS];
	logic [2:0]    next_start;
	policy_t       policy;
	alloc_result_t expected_q [$];

	function automatic alloc_result_t predict_alloc(logic k, logic [2:0] idx,
			logic [15:0] amt);
		alloc_result_t r;
		logic [2:0]    s;
		logic [2:0]    pick;
		bit            found;
		found = 1'b0;
		pick = '0;
		if (k == KIND_LOAD) begin
			slot_free[idx] = amt;
			r.status = ST_LOADED;
			r.slot = idx;
			r.remaining = amt;
			return r;
		end
		if (policy == POL_NEXT) begin
			s = next_start;
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && slot_free[s] >= amt) begin
					found = 1'b1;
					pick = s;
				end
				s = s + 3'd1;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_free[i] >= amt) begin
					if (!found ||
							(policy == POL_BEST && slot_free[i] < slot_free[pick]) ||
							(policy == POL_WORST && slot_free[i] > slot_free[pick])) begin
						pick = 3'(i);
						found = 1'b1;
					end
				end
			end
		end
		if (found) begin
			slot_free[pick] = slot_free[pick] - amt;
			if (policy == POL_NEXT)
				next_start = pick;
			r.status = ST_GRANTED;
			r.slot = pick;
			r.remaining = slot_free[pick];
		end else begin
			r.status = ST_NOFIT;
			r.slot = '0;
			r.remaining = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t: %s", $time, msg);
		fails++;
	endtask

	always @(posedge clk) begin
		alloc_result_t want;
		if (!arst_n) begin
			foreach (slot_free[i])
				slot_free[i] = '0;
			next_start = '0;
			policy = POL_FIRST;
			expected_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				policy = policy_t'(cfg_wdata);
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result transfer with none expected: %0d %0d %0d",
						rsp.status, rsp.chosen_slot, rsp.slot_remaining));
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status is %0d, expected %0d",
							rsp.status, want.status));
					if (rsp.chosen_slot !== want.slot)
						report_mismatch($sformatf("chosen_slot is %0d, expected %0d",
							rsp.chosen_slot, want.slot));
					if (rsp.slot_remaining !== want.remaining)
						report_mismatch($sformatf("slot_remaining is %0d, expected %0d",
							rsp.slot_remaining, want.remaining));
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(predict_alloc(req.kind, req.slot_index, req.amount));
			pending = expected_q.size();
		end
	end

endmodule

### tb/tb_fixed_partition_fit_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed partition fit allocator testbench
// Drives loads and allocation requests under all four fit policies, first a
// short directed sequence and then random phases, with random gaps on both
// channels and a long result hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_fixed_partition_fit_allocator_top;
	import fpfa_pkg::*;

	localparam int SLOTS       = 8;
	localparam int LATENCY     = SLOTS + 3;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 3000;
	localparam int PHASE_ITEMS = 240;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	int          fails;
	int          pending;
	int          idle_cycles;
	int          send_calm;
	bit          hold_rsp_req;
	logic [15:0] last_load;

	fpfa_req_if req_ch();
	fpfa_rsp_if rsp_ch();

	fixed_partition_fit_allocator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	fpfa_alloc_checker #(.SLOTS(SLOTS)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("fixed_partition_fit_allocator_top regression: fail");
				$finish;
			end
		end
	end

	function automatic int random_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : rsp_drain
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp_req) begin
				hold_rsp_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 99) < 2)
					calm_left = $urandom_range(20, 80);
				else if ($urandom_range(0, 99) < 30)
					stall_left = random_gap();
			end
		end
	end

	task automatic push_item(logic k, logic [2:0] idx, logic [15:0] amt);
		int gap;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else if ($urandom_range(0, 99) < 3) begin
			send_calm = $urandom_range(20, 60);
			gap = 0;
		end else if ($urandom_range(0, 99) < 45) begin
			gap = 0;
		end else begin
			gap = random_gap();
		end
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.slot_index <= idx;
		req_ch.amount <= amt;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (pending == 0);
	endtask

	task automatic set_policy(policy_t p);
		drain_results();
		repeat (LATENCY) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(policy_t p, bit with_hold);
		logic [15:0] amt;
		int          pick;
		set_policy(p);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (with_hold && n == PHASE_ITEMS / 2)
				hold_rsp_req = 1'b1;
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 35) begin
				if (pick < 60)
					amt = 16'($urandom_range(0, 1000));
				else if (pick < 85)
					amt = 16'($urandom);
				else
					amt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				last_load = amt;
				push_item(KIND_LOAD, 3'($urandom), amt);
			end else begin
				if (pick < 10)
					amt = '0;
				else if (pick < 60)
					amt = 16'($urandom_range(1, 300));
				else if (pick < 75)
					amt = last_load;
				else
					amt = 16'($urandom);
				push_item(KIND_REQ, 3'($urandom), amt);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = POL_FIRST;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_LOAD;
		req_ch.slot_index = '0;
		req_ch.amount = '0;
		idle_cycles = 0;
		send_calm = 0;
		hold_rsp_req = 1'b0;
		last_load = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_item(KIND_REQ, 3'($urandom), 16'd0);
		push_item(KIND_REQ, 3'($urandom), 16'd1);
		push_item(KIND_LOAD, 3'd0, 16'd100);
		push_item(KIND_LOAD, 3'd1, 16'd40);
		push_item(KIND_LOAD, 3'd2, 16'hFFFF);
		push_item(KIND_LOAD, 3'd3, 16'd40);
		push_item(KIND_LOAD, 3'd7, 16'hFFFF);
		push_item(KIND_LOAD, 3'd5, 16'd300);
		push_item(KIND_REQ, 3'($urandom), 16'd40);
		push_item(KIND_REQ, 3'($urandom), 16'hFFFF);
		push_item(KIND_REQ, 3'($urandom), 16'd0);
		set_policy(POL_BEST);
		push_item(KIND_REQ, 3'($urandom), 16'd40);
		push_item(KIND_REQ, 3'($urandom), 16'd50);
		push_item(KIND_REQ, 3'($urandom), 16'hFFFF);
		set_policy(POL_WORST);
		push_item(KIND_LOAD, 3'd4, 16'd300);
		push_item(KIND_REQ, 3'($urandom), 16'd1);
		push_item(KIND_REQ, 3'($urandom), 16'd2000);
		set_policy(POL_NEXT);
		push_item(KIND_REQ, 3'($urandom), 16'd10);
		push_item(KIND_REQ, 3'($urandom), 16'd20);
		push_item(KIND_REQ, 3'($urandom), 16'd20);
		push_item(KIND_REQ, 3'($urandom), 16'd250);
		push_item(KIND_REQ, 3'($urandom), 16'd300);
		push_item(KIND_REQ, 3'($urandom), 16'd45);

		run_phase(POL_FIRST, 1'b0);
		run_phase(POL_NEXT, 1'b1);
		run_phase(POL_BEST, 1'b0);
		run_phase(POL_WORST, 1'b0);
		for (int ph = 0; ph < 4; ph++)
			run_phase(policy_t'($urandom_range(0, 3)), ph == 1);

		drain_results();
		repeat (LATENCY + 5) @(posedge clk);
		if (fails == 0)
			$display("fixed_partition_fit_allocator_top regression: pass");
		else
			$display("fixed_partition_fit_allocator_top regression: fail");
		$finish;
	end

endmodule
